// File: hdl/dmc_pkg.sv
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types and constants of the direct-mapped write-back cache.
// ----------------------------------------------------------------------------
package dmc_pkg;

	localparam int NUM_LINES      = 64;
	localparam int WORDS_PER_LINE = 16;
	localparam int MEM_WORDS      = 65536;
	localparam int ADDR_W         = 18;
	localparam int DATA_W         = 32;
	localparam int KIND_W         = 2;

	localparam int OFF_W  = $clog2(WORDS_PER_LINE);
	localparam int IDX_W  = $clog2(NUM_LINES);
	localparam int MEM_AW = $clog2(MEM_WORDS);
	localparam int TAG_W  = MEM_AW - IDX_W - OFF_W;
	localparam int LW_AW  = IDX_W + OFF_W;
	localparam int CNT_W  = OFF_W + 1;

	localparam logic [KIND_W-1:0] KIND_READ    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PRELOAD = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] write_data;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              hit;
		logic              wrote_back;
	} rsp_t;

	typedef struct packed {
		logic clr_we;
		logic accept;
		logic lookup;
		logic preload_we;
		logic hit_we;
		logic install;
		logic wb_run;
		logic fill_run;
		logic cnt_clear;
		logic set_dirty;
		logic out_load;
		logic out_live;
	} cmd_t;

	typedef struct packed {
		logic              clr_last;
		logic              is_hit;
		logic              victim_dirty;
		logic [KIND_W-1:0] kind;
		logic              cnt_done;
		logic              out_free;
	} sts_t;

endpackage

// File: hdl/dmc_ctrl.sv
// ----------------------------------------------------------------------------
// dmc_ctrl
// Sequencer of the cache: memory clear, lookup, write-back, fill, response.
// ----------------------------------------------------------------------------
module dmc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  dmc_pkg::sts_t sts,
	output dmc_pkg::cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_LOOKUP = 6'b000100,
		ST_WB     = 6'b001000,
		ST_FILL   = 6'b010000,
		ST_RESP   = 6'b100000
	} state_t;

	state_t state_q, state_nxt;
	logic   rw;

	assign rw = (sts.kind == dmc_pkg::KIND_READ) || (sts.kind == dmc_pkg::KIND_WRITE);
	assign req_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (sts.clr_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				if (rw && !sts.is_hit) begin
					cmd.install   = 1'b1;
					cmd.cnt_clear = 1'b1;
					state_nxt     = sts.victim_dirty ? ST_WB : ST_FILL;
				end else begin
					cmd.preload_we = (sts.kind == dmc_pkg::KIND_PRELOAD);
					cmd.hit_we     = (sts.kind == dmc_pkg::KIND_WRITE);
					cmd.set_dirty  = (sts.kind == dmc_pkg::KIND_WRITE);
					if (sts.out_free) begin
						cmd.out_load = 1'b1;
						cmd.out_live = 1'b1;
						state_nxt    = ST_IDLE;
					end else begin
						state_nxt = ST_RESP;
					end
				end
			end
			ST_WB: begin
				cmd.wb_run = 1'b1;
				if (sts.cnt_done) begin
					cmd.cnt_clear = 1'b1;
					state_nxt     = ST_FILL;
				end
			end
			ST_FILL: begin
				cmd.fill_run = 1'b1;
				if (sts.cnt_done) begin
					cmd.set_dirty = (sts.kind == dmc_pkg::KIND_WRITE);
					state_nxt     = ST_RESP;
				end
			end
			ST_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// File: hdl/dmc_datapath.sv
// ----------------------------------------------------------------------------
// dmc_datapath
// Tag store, line word memory, backing memory, word counter and result register.
// ----------------------------------------------------------------------------
module dmc_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  dmc_pkg::req_t req,
	input  dmc_pkg::cmd_t cmd,
	output dmc_pkg::sts_t sts,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output dmc_pkg::rsp_t rsp
);

	logic [dmc_pkg::TAG_W-1:0]  tag_mem [dmc_pkg::NUM_LINES];
	logic [dmc_pkg::DATA_W-1:0] line_mem [dmc_pkg::NUM_LINES * dmc_pkg::WORDS_PER_LINE];
	logic [dmc_pkg::DATA_W-1:0] back_mem [dmc_pkg::MEM_WORDS];

	logic [dmc_pkg::NUM_LINES-1:0] valid_q, dirty_q;

	logic [dmc_pkg::KIND_W-1:0] kind_q;
	logic [dmc_pkg::TAG_W-1:0]  tag_q, tag_rd_q;
	logic [dmc_pkg::IDX_W-1:0]  idx_q;
	logic [dmc_pkg::OFF_W-1:0]  off_q;
	logic [dmc_pkg::DATA_W-1:0] wdata_q, line_rd_q, back_rd_q, word_q;
	logic [dmc_pkg::CNT_W-1:0]  cnt_q;
	logic [dmc_pkg::OFF_W-1:0]  cnt_lo, cnt_m1;
	logic [dmc_pkg::MEM_AW-1:0] clr_q, req_waddr;
	logic                       hit_q, wb_q, out_valid_q;
	dmc_pkg::rsp_t              out_q, out_nxt;

	logic                       cnt_busy, is_hit, rw;
	logic [dmc_pkg::LW_AW-1:0]  line_raddr, line_waddr;
	logic                       line_we;
	logic [dmc_pkg::DATA_W-1:0] line_wdata, fill_word;
	logic [dmc_pkg::MEM_AW-1:0] back_raddr, back_waddr;
	logic                       back_we;
	logic [dmc_pkg::DATA_W-1:0] back_wdata;

	assign req_waddr = req.address[dmc_pkg::MEM_AW+1:2];
	assign cnt_lo    = cnt_q[dmc_pkg::OFF_W-1:0];
	assign cnt_m1    = cnt_lo - 1'b1;
	// Word cnt-1 is written in the cycle after it is read, while word cnt is read.
	assign cnt_busy  = (cnt_q != '0);
	assign rw        = (kind_q == dmc_pkg::KIND_READ) || (kind_q == dmc_pkg::KIND_WRITE);
	assign is_hit    = valid_q[idx_q] && (tag_rd_q == tag_q);

	assign sts.clr_last     = &clr_q;
	assign sts.is_hit       = is_hit;
	assign sts.victim_dirty = valid_q[idx_q] && dirty_q[idx_q];
	assign sts.kind         = kind_q;
	assign sts.cnt_done     = (cnt_q == dmc_pkg::CNT_W'(dmc_pkg::WORDS_PER_LINE));
	assign sts.out_free     = !out_valid_q || !rsp_stall;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q  <= req.kind;
			off_q   <= req_waddr[dmc_pkg::OFF_W-1:0];
			idx_q   <= req_waddr[dmc_pkg::LW_AW-1:dmc_pkg::OFF_W];
			tag_q   <= req_waddr[dmc_pkg::MEM_AW-1:dmc_pkg::LW_AW];
			wdata_q <= req.write_data;
			tag_rd_q <= tag_mem[req_waddr[dmc_pkg::LW_AW-1:dmc_pkg::OFF_W]];
		end
		if (cmd.install) begin
			tag_mem[idx_q] <= tag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
		end else begin
			if (cmd.install) begin
				valid_q[idx_q] <= 1'b1;
				dirty_q[idx_q] <= 1'b0;
			end
			if (cmd.set_dirty) begin
				dirty_q[idx_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			clr_q <= '0;
		end else begin
			if (cmd.cnt_clear) begin
				cnt_q <= '0;
			end else if (cmd.wb_run || cmd.fill_run) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.clr_we) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// A write miss merges the new word into the line while it is filled.
	assign fill_word = (kind_q == dmc_pkg::KIND_WRITE && cnt_m1 == off_q) ? wdata_q : back_rd_q;

	always_comb begin
		line_raddr = cmd.accept ? req_waddr[dmc_pkg::LW_AW-1:0] : {idx_q, cnt_lo};
		line_we    = 1'b0;
		line_waddr = {idx_q, off_q};
		line_wdata = wdata_q;
		if (cmd.hit_we) begin
			line_we = 1'b1;
		end else if (cmd.fill_run && cnt_busy) begin
			line_we    = 1'b1;
			line_waddr = {idx_q, cnt_m1};
			line_wdata = fill_word;
		end
	end

	always_ff @(posedge clk) begin
		if (line_we) begin
			line_mem[line_waddr] <= line_wdata;
		end
		line_rd_q <= line_mem[line_raddr];
	end

	always_comb begin
		back_raddr = {tag_q, idx_q, cnt_lo};
		back_we    = 1'b0;
		back_waddr = {tag_q, idx_q, off_q};
		back_wdata = wdata_q;
		priority if (cmd.clr_we) begin
			back_we    = 1'b1;
			back_waddr = clr_q;
			back_wdata = '0;
		end else if (cmd.preload_we) begin
			back_we = 1'b1;
		end else if (cmd.wb_run && cnt_busy) begin
			back_we    = 1'b1;
			back_waddr = {tag_rd_q, idx_q, cnt_m1};
			back_wdata = line_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (back_we) begin
			back_mem[back_waddr] <= back_wdata;
		end
		back_rd_q <= back_mem[back_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			word_q <= line_rd_q;
			hit_q  <= is_hit && rw;
			wb_q   <= rw && !is_hit && valid_q[idx_q] && dirty_q[idx_q];
		end else if (cmd.fill_run && cnt_busy && cnt_m1 == off_q) begin
			word_q <= back_rd_q;
		end
	end

	always_comb begin
		if (cmd.out_live) begin
			out_nxt.read_data  = (kind_q == dmc_pkg::KIND_READ) ? line_rd_q : '0;
			out_nxt.hit        = is_hit && rw;
			out_nxt.wrote_back = 1'b0;
		end else begin
			out_nxt.read_data  = (kind_q == dmc_pkg::KIND_READ) ? word_q : '0;
			out_nxt.hit        = hit_q;
			out_nxt.wrote_back = wb_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= out_nxt;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// File: hdl/direct_mapped_write_back_cache_core.sv
// ----------------------------------------------------------------------------
// direct_mapped_write_back_cache_core
// Direct-mapped write-back write-allocate cache with its own backing memory.
// ----------------------------------------------------------------------------
// Channel  Signals                     Carries
// req      req_valid, req_stall, req   kind, byte address, write data
// rsp      rsp_valid, rsp_stall, rsp   read data, hit flag, write-back flag
//
// Preloads, unused kinds and hits go through accept, then tag compare.
// A clean miss adds the fill, a dirty miss the write-back and then the fill;
// each moves one word per cycle through a registered memory read.
// After reset all 65536 words of the backing memory are cleared; req_stall is high.
// A stalled response waits in the output register; the next request is taken.
// A request that finishes while that response is still stalled waits for it.
module direct_mapped_write_back_cache_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  dmc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output dmc_pkg::rsp_t rsp
);

	dmc_pkg::cmd_t cmd;
	dmc_pkg::sts_t sts;

	dmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	dmc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// File: hdl/dmc_checker.sv
// ----------------------------------------------------------------------------
// dmc_checker
// Port-level checks of the cache core, bound to the top level.
// ----------------------------------------------------------------------------
module dmc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input dmc_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input dmc_pkg::rsp_t rsp
);

	// A held response keeps its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// One request is worked on at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while another is in progress");

	// A hit never drains a victim.
	a_hit_no_wb: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.hit && rsp.wrote_back))
		else $error("hit reported together with a write-back");

	// A new response only appears while a request is in progress.
	a_new_rsp_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response appeared without a request in progress");

endmodule

bind direct_mapped_write_back_cache_core dmc_checker u_dmc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

// File: tb/direct_mapped_write_back_cache_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// direct_mapped_write_back_cache_core_test
// Drives reads, writes, preloads and unused kinds into the cache core and checks each
// response against a fixed expectation or a behavioral model of the cache and its memory.
// ----------------------------------------------------------------------------
module direct_mapped_write_back_cache_core_test;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int RANDOM_REQS = 1900;
	localparam int DIRECTED_ROWS = 14;
	localparam logic [dmc_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          req_valid;
	logic          req_stall;
	dmc_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	dmc_pkg::rsp_t rsp;

	direct_mapped_write_back_cache_core dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	// Model state of the cache.
	logic                       mdl_valid [dmc_pkg::NUM_LINES];
	logic                       mdl_dirty [dmc_pkg::NUM_LINES];
	logic [dmc_pkg::TAG_W-1:0]  mdl_tag   [dmc_pkg::NUM_LINES];
	logic [dmc_pkg::DATA_W-1:0] mdl_words [dmc_pkg::NUM_LINES*dmc_pkg::WORDS_PER_LINE];
	logic [dmc_pkg::DATA_W-1:0] mdl_mem   [dmc_pkg::MEM_WORDS];

	dmc_pkg::rsp_t pending_rsps [$];
	int   mismatches;
	int   cycles;
	int   stall_left;
	bit   need_draw = 1'b1;

	typedef struct {
		dmc_pkg::req_t r;
		bit            fixed;
		dmc_pkg::rsp_t want;
	} row_t;
	row_t rows [DIRECTED_ROWS];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic dmc_pkg::rsp_t cache_access(dmc_pkg::req_t r);
		dmc_pkg::rsp_t o;
		logic [dmc_pkg::MEM_AW-1:0] wa;
		logic [dmc_pkg::OFF_W-1:0] off;
		logic [dmc_pkg::IDX_W-1:0] idx;
		logic [dmc_pkg::TAG_W-1:0] tg;
		logic [dmc_pkg::MEM_AW-1:0] home;
		o = '0;
		wa = r.address[dmc_pkg::MEM_AW+1:2];
		off = wa[dmc_pkg::OFF_W-1:0];
		idx = wa[dmc_pkg::OFF_W +: dmc_pkg::IDX_W];
		tg = wa[dmc_pkg::MEM_AW-1 -: dmc_pkg::TAG_W];
		if (r.kind == dmc_pkg::KIND_PRELOAD) begin
			mdl_mem[wa] = r.write_data;
		end else if (r.kind == dmc_pkg::KIND_READ || r.kind == dmc_pkg::KIND_WRITE) begin
			if (mdl_valid[idx] && mdl_tag[idx] == tg) begin
				o.hit = 1'b1;
			end else begin
				if (mdl_valid[idx] && mdl_dirty[idx]) begin
					home = {mdl_tag[idx], idx, {dmc_pkg::OFF_W{1'b0}}};
					for (int i = 0; i < dmc_pkg::WORDS_PER_LINE; i++)
						mdl_mem[home + i] = mdl_words[idx*dmc_pkg::WORDS_PER_LINE + i];
					o.wrote_back = 1'b1;
				end
				home = {tg, idx, {dmc_pkg::OFF_W{1'b0}}};
				for (int i = 0; i < dmc_pkg::WORDS_PER_LINE; i++)
					mdl_words[idx*dmc_pkg::WORDS_PER_LINE + i] = mdl_mem[home + i];
				mdl_tag[idx] = tg;
				mdl_valid[idx] = 1'b1;
				mdl_dirty[idx] = 1'b0;
			end
			if (r.kind == dmc_pkg::KIND_READ) begin
				o.read_data = mdl_words[idx*dmc_pkg::WORDS_PER_LINE + off];
			end else begin
				mdl_words[idx*dmc_pkg::WORDS_PER_LINE + off] = r.write_data;
				mdl_dirty[idx] = 1'b1;
			end
		end
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [dmc_pkg::DATA_W-1:0] got,
			logic [dmc_pkg::DATA_W-1:0] want);
		mismatches++;
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
	endtask

	// Directed rows with a typed expectation are checked against it; all other
	// requests are checked against the model.
	task automatic send_req(dmc_pkg::req_t r, bit fixed, dmc_pkg::rsp_t want);
		dmc_pkg::rsp_t p;
		int gap;
		gap = $urandom_range(0, 16);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		p = cache_access(r);
		req = r;
		req_valid = 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		pending_rsps.push_back(fixed ? want : p);
		@(negedge clk);
		req_valid = 1'b0;
	endtask

	function automatic dmc_pkg::req_t mk(logic [dmc_pkg::KIND_W-1:0] k,
			logic [dmc_pkg::ADDR_W-1:0] a, logic [dmc_pkg::DATA_W-1:0] d);
		dmc_pkg::req_t r;
		r.kind = k;
		r.address = a;
		r.write_data = d;
		return r;
	endfunction

	// Random addresses favor a few tags over a few lines so that hits, conflicts
	// and dirty evictions all occur often.
	function automatic logic [dmc_pkg::ADDR_W-1:0] pick_addr();
		logic [dmc_pkg::ADDR_W-1:0] a;
		a = dmc_pkg::ADDR_W'($urandom);
		if ($urandom_range(0, 9) < 8) begin
			a[dmc_pkg::ADDR_W-1:12] = (dmc_pkg::ADDR_W-12)'($urandom_range(0, 3) == 0 ?
				$urandom : $urandom_range(0, 2));
			a[11:6] = 6'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3));
		end
		return a;
	endfunction

	// Response side: compare with the oldest expectation.
	always @(posedge clk) begin
		dmc_pkg::rsp_t want;
		cycles <= cycles + 1;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsps.size() == 0) begin
				report_mismatch("unexpected response", rsp.read_data, '0);
			end else begin
				want = pending_rsps.pop_front();
				if (rsp.read_data !== want.read_data)
					report_mismatch("read_data", rsp.read_data, want.read_data);
				if (rsp.hit !== want.hit)
					report_mismatch("hit", dmc_pkg::DATA_W'(rsp.hit),
						dmc_pkg::DATA_W'(want.hit));
				if (rsp.wrote_back !== want.wrote_back)
					report_mismatch("wrote_back", dmc_pkg::DATA_W'(rsp.wrote_back),
						dmc_pkg::DATA_W'(want.wrote_back));
			end
		end
	end

	// Each response is held off for a freshly drawn number of cycles.
	always @(negedge clk) begin
		if (rsp_valid && need_draw) begin
			stall_left = $urandom_range(0, 16);
			need_draw = 1'b0;
		end
		if (rsp_valid && stall_left > 0) begin
			stall_left = stall_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
			if (rsp_valid) need_draw = 1'b1;
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		dmc_pkg::rsp_t z;
		dmc_pkg::rsp_t w;
		logic [dmc_pkg::KIND_W-1:0] k;
		z = '0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		for (int i = 0; i < dmc_pkg::NUM_LINES; i++) begin
			mdl_valid[i] = 1'b0;
			mdl_dirty[i] = 1'b0;
			mdl_tag[i] = '0;
		end
		for (int i = 0; i < dmc_pkg::NUM_LINES*dmc_pkg::WORDS_PER_LINE; i++) mdl_words[i] = '0;
		for (int i = 0; i < dmc_pkg::MEM_WORDS; i++) mdl_mem[i] = '0;

		w = '0;
		// Directed table; fixed expectations only where they are obvious.
		rows[0]  = '{mk(dmc_pkg::KIND_READ, 18'h00000, 32'h0), 1, z};
		rows[1]  = '{mk(dmc_pkg::KIND_READ, 18'h00004, 32'h0), 1, '{32'h0, 1'b1, 1'b0}};
		rows[2]  = '{mk(dmc_pkg::KIND_PRELOAD, 18'h3FFFF, 32'hFFFFFFFF), 1, z};
		rows[3]  = '{mk(dmc_pkg::KIND_READ, 18'h3FFFC, 32'h0), 0, z};
		rows[4]  = '{mk(dmc_pkg::KIND_WRITE, 18'h3FFFD, 32'hA5A5A5A5), 1,
			'{32'h0, 1'b1, 1'b0}};
		rows[5]  = '{mk(KIND_UNUSED, 18'h3FFFF, 32'hFFFFFFFF), 1, z};
		rows[6]  = '{mk(dmc_pkg::KIND_PRELOAD, 18'h3FFFC, 32'h12345678), 1, z};
		rows[7]  = '{mk(dmc_pkg::KIND_READ, 18'h3FFFC, 32'h0), 1,
			'{32'hA5A5A5A5, 1'b1, 1'b0}};
		rows[8]  = '{mk(dmc_pkg::KIND_READ, 18'h00FFC, 32'h0), 1, '{32'h0, 1'b0, 1'b1}};
		rows[9]  = '{mk(dmc_pkg::KIND_READ, 18'h3FFFC, 32'h0), 1,
			'{32'hA5A5A5A5, 1'b0, 1'b0}};
		rows[10] = '{mk(dmc_pkg::KIND_WRITE, 18'h00000, 32'hFFFFFFFF), 0, z};
		rows[11] = '{mk(dmc_pkg::KIND_WRITE, 18'h01000, 32'h00000001), 0, z};
		rows[12] = '{mk(dmc_pkg::KIND_READ, 18'h00003, 32'hFFFFFFFF), 0, z};
		rows[13] = '{mk(KIND_UNUSED, 18'h00000, 32'h0), 1, z};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++) send_req(rows[i].r, rows[i].fixed, rows[i].want);

		for (int n = 0; n < RANDOM_REQS; n++) begin
			if (n == RANDOM_REQS / 2) begin
				while (pending_rsps.size() != 0) @(negedge clk);
			end
			k = $urandom_range(0, 19) == 0 ? KIND_UNUSED :
				dmc_pkg::KIND_W'($urandom_range(0, 2));
			send_req(mk(k, pick_addr(), $urandom), 0, w);
		end

		while (pending_rsps.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/dmc_pkg.sv
hdl/dmc_ctrl.sv
hdl/dmc_datapath.sv
hdl/direct_mapped_write_back_cache_core.sv
hdl/dmc_checker.sv
tb/direct_mapped_write_back_cache_core_test.sv
